### src/adaptive_mean_threshold_3x3_unit_assert.svh
// Assertion macros shared by the threshold unit and its output queue.
// The same-cycle form checks a consequence at the edge of the cause.
// The next-cycle form checks it at the following clock edge.
`ifndef ADAPTIVE_MEAN_THRESHOLD_3X3_UNIT_ASSERT_SVH
`define ADAPTIVE_MEAN_THRESHOLD_3X3_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define AMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define AMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define AMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define AMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/amt3x3_pkg.sv
package amt3x3_pkg;

    // Pixel and register field widths
    localparam int PIX_BITS      = 8;
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_OFS_BITS  = 8;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MEAN_OFFSET  = 2'd2;

    // Register reset values
    localparam logic [CFG_W_BITS-1:0]   FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_H_BITS-1:0]   FRAME_HEIGHT_RST = 13'd480;
    localparam logic [CFG_OFS_BITS-1:0] MEAN_OFFSET_RST  = 8'd3;

    // Default frame limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Output queue depth
    localparam int OUT_FIFO_DEPTH = 8;

    // Neighbour sum and reciprocal divide: floor(x/3) = (x*43691)>>17,
    // floor(x/5) = (x*52429)>>18, exact for any 11-bit sum
    localparam int SUM_BITS   = 11;
    localparam int RECIP_BITS = 16;
    localparam logic [RECIP_BITS-1:0] RECIP_3 = 16'd43691;
    localparam logic [RECIP_BITS-1:0] RECIP_5 = 16'd52429;
    localparam int SHIFT_3 = 17;
    localparam int SHIFT_5 = 18;
    localparam int SHIFT_8 = 3;

    // Neighbour count: corner, edge, interior
    typedef enum logic [1:0] {
        DIV_3,
        DIV_5,
        DIV_8
    } t_div;

    // One line store entry: row above and current row at a column
    typedef struct packed {
        logic [PIX_BITS-1:0] upper;
        logic [PIX_BITS-1:0] middle;
    } t_line_pair;

    // One result word
    typedef struct packed {
        logic foreground;
        logic frame_end;
    } t_result;

endpackage

### src/amt3x3_in_if.sv
interface amt3x3_in_if;
    import amt3x3_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [PIX_BITS-1:0] pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink (input valid, input kind, input pixel, output ready);

endinterface

### src/amt3x3_out_if.sv
interface amt3x3_out_if;

    logic valid;
    logic ready;
    logic foreground;
    logic frame_end;

    modport source (output valid, output foreground, output frame_end, input ready);
    modport sink (input valid, input foreground, input frame_end, output ready);

endinterface

### src/amt3x3_line_mem.sv
module amt3x3_line_mem #(
    parameter int DEPTH     = amt3x3_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [ADDR_BITS-1:0]   i_rd_addr,
    output amt3x3_pkg::t_line_pair o_rd_data,
    input  logic                   i_wr_en,
    input  logic [ADDR_BITS-1:0]   i_wr_addr,
    input  amt3x3_pkg::t_line_pair i_wr_data
);
    import amt3x3_pkg::*;

    t_line_pair r_mem [DEPTH];
    t_line_pair r_rd_data;

    // Write one column pair
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/amt3x3_out_fifo.sv
`include "adaptive_mean_threshold_3x3_unit_assert.svh"

module amt3x3_out_fifo #(
    parameter int DEPTH      = amt3x3_pkg::OUT_FIFO_DEPTH,
    parameter int LEVEL_BITS = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  amt3x3_pkg::t_result   i_push_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output amt3x3_pkg::t_result   o_data,
    output logic [LEVEL_BITS-1:0] o_level
);
    import amt3x3_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_result               r_buf [DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [LEVEL_BITS-1:0] r_count;
    logic [PTR_BITS-1:0]   n_wr_ptr;
    logic [PTR_BITS-1:0]   n_rd_ptr;
    logic [LEVEL_BITS-1:0] n_count;
    logic                  w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_level = r_count;

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (i_push && !w_pop) begin
            n_count = r_count + LEVEL_BITS'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - LEVEL_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    `AMT_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push && !w_pop, r_count < LEVEL_BITS'(DEPTH))
    `AMT_ASSERT_IMP(a_level_bound, i_clk, i_rst_n, 1'b1, r_count <= LEVEL_BITS'(DEPTH))
    `AMT_ASSERT_NXT(a_push_shows, i_clk, i_rst_n, i_push && (r_count == '0), o_valid)

endmodule

### src/adaptive_mean_threshold_3x3_unit.sv
// Adaptive mean threshold over a 3x3 neighbourhood. Feed 8-bit grey pixels in
// raster order on i_pix (kind 0), one per clock; after the last pixel of a
// frame send frame_width+1 flush words (kind 1) to drain the remaining results.
// Each result on o_res says whether its pixel lies below the truncated mean of
// its in-image 8-neighbours (3 at a corner, 5 on an edge, 8 inside) minus
// mean_offset; the result for the last pixel of the frame carries frame_end.
// Results come out in raster order, starting once a pixel's lower neighbours
// have arrived, i.e. frame_width+1 words after the pixel itself. The unit takes
// one word per clock while i_pix.ready is high: each word makes one read and
// one write of a single line store memory (both rows packed in one entry),
// and the window load, neighbour sum and divide-compare follow as a
// three-stage pipeline behind it. A result leaves the last stage into the
// output queue and can be taken in the cycle after it enters. i_pix.ready
// drops only when the 8-word output queue plus the results still in the
// pipeline would fill it. Width and height are clamped to [2, MAX_WIDTH] and
// [2, MAX_HEIGHT]; write the registers only while no frame is in progress.
`include "adaptive_mean_threshold_3x3_unit_assert.svh"

module adaptive_mean_threshold_3x3_unit #(
    parameter int MAX_WIDTH  = amt3x3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = amt3x3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    amt3x3_in_if.sink                            i_pix,
    amt3x3_out_if.source                         o_res,
    input  logic                                 i_cfg_we,
    input  logic [amt3x3_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [amt3x3_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import amt3x3_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int PW   = $clog2(MAX_WIDTH + 2);
    localparam int EWW  = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;
    localparam int EHW  = (HW > CFG_H_BITS) ? HW : CFG_H_BITS;
    localparam int LW   = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int LVW  = LW + 1;
    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

    // Configuration registers
    logic [CFG_W_BITS-1:0]   r_frame_width;
    logic [CFG_H_BITS-1:0]   r_frame_height;
    logic [CFG_OFS_BITS-1:0] r_mean_offset;

    // Clamped frame size
    logic [EWW-1:0] w_fw_ext;
    logic [EHW-1:0] w_fh_ext;
    logic [WW-1:0]  w_eff_w;
    logic [HW-1:0]  w_eff_h;

    // Position counters
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;
    logic [PW-1:0] r_pend;
    logic [CW-1:0] n_in_col;
    logic [RW-1:0] n_in_row;
    logic [CW-1:0] n_out_col;
    logic [RW-1:0] n_out_row;
    logic [PW-1:0] n_pend;
    logic          w_pos_clear;

    // Accept-cycle decode
    logic                w_accept;
    logic                w_draining;
    logic                w_ignore;
    logic                w_live;
    logic                w_emit;
    logic                w_last_drain;
    logic                w_fend;
    logic [PIX_BITS-1:0] w_val;
    logic [WW-1:0]       w_in_col_inc;
    logic [HW-1:0]       w_in_row_inc;
    logic [WW-1:0]       w_out_col_inc;
    logic [HW-1:0]       w_out_row_inc;
    logic [PW-1:0]       w_drain_len;
    logic                w_has_l;
    logic                w_has_r;
    logic                w_has_t;
    logic                w_has_b;

    // Stage 1: line store read returns
    logic                r_s1_valid;
    logic                r_s1_emit;
    logic [PIX_BITS-1:0] r_s1_val;
    logic [CW-1:0]       r_s1_col;
    logic                r_s1_has_l;
    logic                r_s1_has_r;
    logic                r_s1_has_t;
    logic                r_s1_has_b;
    logic                r_s1_fend;

    // Line store access and forwarding
    t_line_pair w_mem_rd;
    t_line_pair w_rd;
    t_line_pair w_wr_data;
    logic       w_fwd_hit;
    logic       r_fwd;
    t_line_pair r_fwd_data;

    // Window, row-major, centre at 4
    logic [PIX_BITS-1:0] r_win [9];

    // Stage 2: window holds the result's neighbourhood
    logic                r_s2_valid;
    logic                r_s2_has_l;
    logic                r_s2_has_r;
    logic                r_s2_has_t;
    logic                r_s2_has_b;
    logic                r_s2_fend;
    logic [SUM_BITS-1:0] w_sum;
    t_div                w_div;

    // Stage 3: divide and compare
    logic                 r_s3_valid;
    logic [SUM_BITS-1:0]  r_s3_sum;
    logic [PIX_BITS-1:0]  r_s3_centre;
    t_div                 r_s3_div;
    logic                 r_s3_fend;
    logic [RECIP_BITS-1:0] w_recip;
    logic [PROD_BITS-1:0] w_prod;
    logic [PIX_BITS-1:0]  w_mean;
    logic                 w_fg;
    t_result              w_push_data;

    // Output queue
    t_result        w_out;
    logic           w_out_valid;
    logic [LW-1:0]  w_level;
    logic [LVW-1:0] w_inflight;
    logic [LVW-1:0] w_credit_used;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_mean_offset  <= MEAN_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IDX_FRAME_HEIGHT: r_frame_height <= i_cfg_data[CFG_H_BITS-1:0];
                CFG_IDX_MEAN_OFFSET:  r_mean_offset  <= i_cfg_data[CFG_OFS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp frame size into the supported range
    assign w_fw_ext = EWW'(r_frame_width);
    assign w_fh_ext = EHW'(r_frame_height);

    always_comb begin
        if (w_fw_ext < EWW'(2)) begin
            w_eff_w = WW'(2);
        end else if (w_fw_ext > EWW'(MAX_WIDTH)) begin
            w_eff_w = WW'(MAX_WIDTH);
        end else begin
            w_eff_w = WW'(w_fw_ext);
        end
        if (w_fh_ext < EHW'(2)) begin
            w_eff_h = HW'(2);
        end else if (w_fh_ext > EHW'(MAX_HEIGHT)) begin
            w_eff_h = HW'(MAX_HEIGHT);
        end else begin
            w_eff_h = HW'(w_fh_ext);
        end
    end

    // Decode the incoming word; a flush before the first pixel is dropped
    assign w_accept      = i_pix.valid && i_pix.ready;
    assign w_draining    = (r_pend != '0);
    assign w_ignore      = !w_draining && i_pix.kind && (r_in_row == '0) && (r_in_col == '0);
    assign w_live        = w_accept && !w_ignore;
    assign w_val         = (w_draining || i_pix.kind) ? '0 : i_pix.pixel;
    assign w_emit        = w_draining || (r_in_row >= RW'(2))
                           || ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign w_last_drain  = w_draining && (r_pend == PW'(1));
    assign w_in_col_inc  = WW'(r_in_col) + WW'(1);
    assign w_in_row_inc  = HW'(r_in_row) + HW'(1);
    assign w_out_col_inc = WW'(r_out_col) + WW'(1);
    assign w_out_row_inc = HW'(r_out_row) + HW'(1);
    assign w_drain_len   = PW'(w_eff_w) + PW'(1);

    // Border flags of the result position
    assign w_has_l = (r_out_col != '0);
    assign w_has_r = (w_out_col_inc < w_eff_w);
    assign w_has_t = (r_out_row != '0);
    assign w_has_b = (w_out_row_inc < w_eff_h);
    assign w_fend  = ((w_out_row_inc >= w_eff_h) && (w_out_col_inc >= w_eff_w)) || w_last_drain;

    // Advance input and output positions; frame end clears everything
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pend    = r_pend;
        if (w_live) begin
            if (w_draining) begin
                n_pend = r_pend - PW'(1);
            end
            if (w_in_col_inc >= w_eff_w) begin
                n_in_col = '0;
                if (!w_draining) begin
                    if (w_in_row_inc >= w_eff_h) begin
                        n_pend = w_drain_len;
                    end else begin
                        n_in_row = RW'(w_in_row_inc);
                    end
                end
            end else begin
                n_in_col = CW'(w_in_col_inc);
            end
            if (w_emit) begin
                if (w_fend) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_pend    = '0;
                end else if (w_out_col_inc >= w_eff_w) begin
                    n_out_col = '0;
                    n_out_row = RW'(w_out_row_inc);
                end else begin
                    n_out_col = CW'(w_out_col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pend    <= n_pend;
        end
    end

    // All positions back at the frame start
    assign w_pos_clear = (r_in_col == '0) && (r_in_row == '0) && (r_out_col == '0)
                         && (r_out_row == '0) && (r_pend == '0);

    // Stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= w_live;
            if (w_live) begin
                r_fwd <= w_fwd_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_live) begin
            r_s1_emit  <= w_emit;
            r_s1_val   <= w_val;
            r_s1_col   <= r_in_col;
            r_s1_has_l <= w_has_l;
            r_s1_has_r <= w_has_r;
            r_s1_has_t <= w_has_t;
            r_s1_has_b <= w_has_b;
            r_s1_fend  <= w_fend;
            r_fwd_data <= w_wr_data;
        end
    end

    // Read-modify-write of the line store; forward when the next word
    // reads the column being written
    assign w_fwd_hit = w_live && r_s1_valid && (r_in_col == r_s1_col);
    assign w_rd      = r_fwd ? r_fwd_data : w_mem_rd;
    assign w_wr_data = '{upper: w_rd.middle, middle: r_s1_val};

    amt3x3_line_mem #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_live),
        .i_rd_addr (r_in_col),
        .o_rd_data (w_mem_rd),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (w_wr_data)
    );

    // Shift the window left and load the new right column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= w_rd.upper;
            r_win[5] <= w_rd.middle;
            r_win[8] <= r_s1_val;
        end
    end

    // Stage 2 capture: only words that make a result go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_has_l <= r_s1_has_l;
        r_s2_has_r <= r_s1_has_r;
        r_s2_has_t <= r_s1_has_t;
        r_s2_has_b <= r_s1_has_b;
        r_s2_fend  <= r_s1_fend;
    end

    // Sum the in-image neighbours
    always_comb begin
        w_sum = (r_s2_has_t ? SUM_BITS'(r_win[1]) : '0)
              + (r_s2_has_b ? SUM_BITS'(r_win[7]) : '0)
              + (r_s2_has_l ? SUM_BITS'(r_win[3]) : '0)
              + (r_s2_has_r ? SUM_BITS'(r_win[5]) : '0)
              + ((r_s2_has_t && r_s2_has_l) ? SUM_BITS'(r_win[0]) : '0)
              + ((r_s2_has_t && r_s2_has_r) ? SUM_BITS'(r_win[2]) : '0)
              + ((r_s2_has_b && r_s2_has_l) ? SUM_BITS'(r_win[6]) : '0)
              + ((r_s2_has_b && r_s2_has_r) ? SUM_BITS'(r_win[8]) : '0);
    end

    // Pick the neighbour count
    always_comb begin
        if ((r_s2_has_t && r_s2_has_b) && (r_s2_has_l && r_s2_has_r)) begin
            w_div = DIV_8;
        end else if (!(r_s2_has_t && r_s2_has_b) && !(r_s2_has_l && r_s2_has_r)) begin
            w_div = DIV_3;
        end else begin
            w_div = DIV_5;
        end
    end

    // Stage 3 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_sum    <= w_sum;
        r_s3_centre <= r_win[4];
        r_s3_div    <= w_div;
        r_s3_fend   <= r_s2_fend;
    end

    // Divide by reciprocal multiply (by a shift for eight neighbours), then compare centre plus offset
    assign w_recip = (r_s3_div == DIV_3) ? RECIP_3 : RECIP_5;
    assign w_prod  = PROD_BITS'(r_s3_sum) * PROD_BITS'(w_recip);

    always_comb begin
        unique case (r_s3_div)
            DIV_3:   w_mean = w_prod[SHIFT_3 +: PIX_BITS];
            DIV_5:   w_mean = w_prod[SHIFT_5 +: PIX_BITS];
            DIV_8:   w_mean = r_s3_sum[SHIFT_8 +: PIX_BITS];
            default: w_mean = '0;
        endcase
    end

    assign w_fg = ({1'b0, r_s3_centre} + {1'b0, r_mean_offset}) < {1'b0, w_mean};
    assign w_push_data = '{foreground: w_fg, frame_end: r_s3_fend};

    // Output queue parts the pipeline from the consumer
    amt3x3_out_fifo #(
        .DEPTH      (OUT_FIFO_DEPTH),
        .LEVEL_BITS (LW)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s3_valid),
        .i_push_data (w_push_data),
        .o_valid     (w_out_valid),
        .i_ready     (o_res.ready),
        .o_data      (w_out),
        .o_level     (w_level)
    );

    assign o_res.valid      = w_out_valid;
    assign o_res.foreground = w_out.foreground;
    assign o_res.frame_end  = w_out.frame_end;

    // Take a word only while every result in flight still has a queue slot
    assign w_inflight    = LVW'(r_s1_valid && r_s1_emit) + LVW'(r_s2_valid) + LVW'(r_s3_valid);
    assign w_credit_used = LVW'(w_level) + w_inflight;
    assign i_pix.ready   = (w_credit_used < LVW'(OUT_FIFO_DEPTH));

    `AMT_ASSERT_IMP(a_fwd_only_col0, i_clk, i_rst_n, w_fwd_hit, r_in_col == '0)
    `AMT_ASSERT_NXT(a_drain_counts_down, i_clk, i_rst_n, w_live && w_draining, r_pend < $past(r_pend))
    `AMT_ASSERT_NXT(a_frame_end_clears, i_clk, i_rst_n, w_live && w_emit && w_fend, w_pos_clear)
    `AMT_ASSERT_IMP(a_credit_bound, i_clk, i_rst_n, 1'b1, w_credit_used <= LVW'(OUT_FIFO_DEPTH))

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import amt3x3_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRINT_LIMIT    = 40;

    // Pixel content of a generated frame
    typedef enum int {
        TEX_UNIFORM,
        TEX_FLAT,
        TEX_BINARY
    } t_texture;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    amt3x3_in_if  pix_if ();
    amt3x3_out_if res_if ();

    adaptive_mean_threshold_3x3_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Threshold predictor state: registers, line stores, window, positions
    logic [CFG_W_BITS-1:0]   width_reg  = FRAME_WIDTH_RST;
    logic [CFG_H_BITS-1:0]   height_reg = FRAME_HEIGHT_RST;
    logic [CFG_OFS_BITS-1:0] offset_reg = MEAN_OFFSET_RST;
    logic [PIX_BITS-1:0]     row_above   [MAX_WIDTH_DEF];
    logic [PIX_BITS-1:0]     row_current [MAX_WIDTH_DEF];
    logic [PIX_BITS-1:0]     win [9];
    int unsigned in_col, in_row, out_col, out_row, drain_left;

    t_result marks_due [$];
    int      mismatches;
    int      src_idle_pct;
    int      sink_idle_pct;
    int      hold_req;
    int      hold_left;
    int      words_sent;

    function automatic int unsigned frame_cols();
        if (width_reg < 2) return 2;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic int unsigned frame_rows();
        if (height_reg < 2) return 2;
        if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
        return height_reg;
    endfunction

    // Advance the predictor by one accepted word and queue the mark it yields
    task automatic classify_word(input logic kind, input logic [PIX_BITS-1:0] pix);
        int unsigned w, h, idx;
        bit draining, emit, last_drain, has_l, has_r, has_t, has_b, fend;
        logic [PIX_BITS-1:0] val;
        int sum, cnt, mean, centre, r;
        t_result mark;
        w = frame_cols();
        h = frame_rows();
        draining = (drain_left != 0);
        last_drain = 1'b0;
        // drop a flush word that comes before the first pixel of a frame
        if (!draining && kind && in_row == 0 && in_col == 0)
            return;
        val = (draining || kind) ? '0 : pix;
        idx = in_col;
        emit = draining || in_row >= 2 || (in_row == 1 && in_col >= 1);

        // shift the window left and load the new right column
        for (r = 0; r < 3; r++) begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = row_above[idx];
        win[5] = row_current[idx];
        win[8] = val;
        row_above[idx]   = row_current[idx];
        row_current[idx] = val;

        // advance the input position
        if (draining) begin
            drain_left--;
            if (drain_left == 0)
                last_drain = 1'b1;
        end
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (!draining) begin
                if (in_row + 1 >= h)
                    drain_left = w + 1;
                else
                    in_row++;
            end
        end else begin
            in_col++;
        end

        if (!emit)
            return;

        // mean of the in-image neighbours of the output position
        has_l = out_col > 0;
        has_r = out_col + 1 < w;
        has_t = out_row > 0;
        has_b = out_row + 1 < h;
        sum = 0;
        cnt = 0;
        if (has_t) begin sum += win[1]; cnt++; end
        if (has_b) begin sum += win[7]; cnt++; end
        if (has_l) begin sum += win[3]; cnt++; end
        if (has_r) begin sum += win[5]; cnt++; end
        if (has_t && has_l) begin sum += win[0]; cnt++; end
        if (has_t && has_r) begin sum += win[2]; cnt++; end
        if (has_b && has_l) begin sum += win[6]; cnt++; end
        if (has_b && has_r) begin sum += win[8]; cnt++; end
        mean = sum / cnt - int'(offset_reg);
        centre = win[4];

        fend = (out_row + 1 >= h && out_col + 1 >= w) || last_drain;
        mark.foreground = (centre < mean);
        mark.frame_end = fend;
        marks_due.push_back(mark);

        if (fend) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            drain_left = 0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic want, input logic got);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH %s: expected %0b got %0b at %0t", what, want, got, $realtime);
    endtask

    // Offer one word, hold it until taken, then leave a random gap
    task automatic send_word(input logic kind, input logic [PIX_BITS-1:0] pix);
        int gap;
        pix_if.valid <= 1'b1;
        pix_if.kind  <= kind;
        pix_if.pixel <= pix;
        do @(posedge i_clk); while (!pix_if.ready);
        classify_word(kind, pix);
        @(negedge i_clk);
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected mark has come out
    task automatic settle();
        pix_if.valid <= 1'b0;
        do @(negedge i_clk); while (marks_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IDX_FRAME_WIDTH:  width_reg  = value[CFG_W_BITS-1:0];
            CFG_IDX_FRAME_HEIGHT: height_reg = value[CFG_H_BITS-1:0];
            CFG_IDX_MEAN_OFFSET:  offset_reg = value[CFG_OFS_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_frame(input int wv, input int hv, input int ov);
        write_reg(CFG_IDX_FRAME_WIDTH, CFG_DATA_BITS'(wv));
        write_reg(CFG_IDX_FRAME_HEIGHT, CFG_DATA_BITS'(hv));
        write_reg(CFG_IDX_MEAN_OFFSET, CFG_DATA_BITS'(ov));
    endtask

    // Send one frame and its drain; broken_pct mixes in flush and stray pixel words
    task automatic run_frame(input t_texture tex, input int broken_pct);
        int unsigned w, h, n;
        int base, t;
        logic [PIX_BITS-1:0] p;
        logic k;
        w = frame_cols();
        h = frame_rows();
        base = $urandom_range(255);
        // stray flush words while idle are dropped by the block
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(2, 1)) send_word(1'b1, PIX_BITS'($urandom));
        for (n = 0; n < w * h; n++) begin
            case (tex)
                TEX_UNIFORM: p = PIX_BITS'($urandom_range(255));
                TEX_FLAT: begin
                    t = base + int'($urandom_range(16)) - 8;
                    p = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : PIX_BITS'(t);
                end
                default: p = $urandom_range(1) ? 8'hFF : 8'h00;
            endcase
            k = ($urandom_range(99) < broken_pct);
            send_word(k, p);
            words_sent++;
        end
        // drain; a pixel word here is taken as a flush
        repeat (w + 1) begin
            k = !($urandom_range(99) < broken_pct * 3);
            send_word(k, PIX_BITS'($urandom_range(255)));
            words_sent++;
        end
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each taken mark with the oldest expectation
    always @(posedge i_clk) begin : check_marks
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (marks_due.size() == 0) begin
                report_mismatch("unexpected result word, foreground", 1'bx, res_if.foreground);
            end else begin
                want = marks_due.pop_front();
                if (res_if.foreground !== want.foreground)
                    report_mismatch("foreground", want.foreground, res_if.foreground);
                if (res_if.frame_end !== want.frame_end)
                    report_mismatch("frame_end", want.frame_end, res_if.frame_end);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("adaptive_mean_threshold_3x3_unit test failed");
                $finish;
            end
        end
    end

    // Flush words before any pixel are ignored
    task automatic test_idle_flush();
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'hFF);
        send_word(1'b1, 8'h5A);
        settle();
    endtask

    // Wide two-row frame: long line store walk and a long drain
    task automatic test_line_fill();
        set_frame(100, 0, 0);
        run_frame(TEX_UNIFORM, 0);
        settle();
    endtask

    // Small frame hitting corners, edges, a flush inside and a pixel while draining
    task automatic test_corner_cases();
        logic [PIX_BITS-1:0] pattern [9] = '{8'd0, 8'd255, 8'd0,
                                             8'd255, 8'd0, 8'd255,
                                             8'd0, 8'd255, 8'd77};
        int i;
        set_frame(3, 3, 0);
        for (i = 0; i < 8; i++)
            send_word(1'b0, pattern[i]);
        send_word(1'b1, pattern[8]);
        send_word(1'b0, 8'hC3);
        repeat (3) send_word(1'b1, 8'h3C);
        settle();
    endtask

    // Registers below the minimum clamp to a 2x2 frame; top offset
    task automatic test_min_frame();
        set_frame(1, 1, 255);
        run_frame(TEX_UNIFORM, 0);
        settle();
    endtask

    // Tall frame at the narrowest width
    task automatic test_tall_frame();
        set_frame(0, 40, 2);
        run_frame(TEX_FLAT, 0);
        settle();
    endtask

    // Hold the receiver off while the sender keeps offering words
    task automatic test_backpressure();
        settle();
        set_frame(16, 4, 5);
        hold_req = HOLD_CYCLES;
        run_frame(TEX_UNIFORM, 0);
        settle();
    endtask

    task automatic test_random_frames(input int target);
        int start, pick, wv, hv, ov;
        bit first;
        start = words_sent;
        first = 1'b1;
        while (words_sent - start < target) begin
            if (first || $urandom_range(99) < 40) begin
                settle();
                pick = $urandom_range(99);
                wv = (pick < 70) ? $urandom_range(12, 2) :
                     (pick < 90) ? $urandom_range(48, 13) : $urandom_range(1);
                pick = $urandom_range(99);
                hv = (pick < 85) ? $urandom_range(8, 2) : $urandom_range(1);
                pick = $urandom_range(99);
                ov = (pick < 60) ? $urandom_range(16) :
                     (pick < 85) ? $urandom_range(64, 17) : $urandom_range(255);
                set_frame(wv, hv, ov);
                first = 1'b0;
            end
            run_frame(t_texture'($urandom_range(2)), ($urandom_range(99) < 30) ? 10 : 0);
        end
        settle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        pix_if.valid = 1'b0;
        pix_if.kind  = 1'b0;
        pix_if.pixel = '0;
        res_if.ready = 1'b0;
        mismatches   = 0;
        hold_req     = 0;
        hold_left    = 0;
        words_sent   = 0;
        in_col       = 0;
        in_row       = 0;
        out_col      = 0;
        out_row      = 0;
        drain_left   = 0;
        foreach (win[i])
            win[i] = '0;
        src_idle_pct  = 16;
        sink_idle_pct = 82;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_flush();
        test_line_fill();
        test_corner_cases();
        test_min_frame();
        test_tall_frame();
        test_random_frames(90);

        src_idle_pct  = 82;
        sink_idle_pct = 16;
        test_random_frames(90);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_backpressure();
        test_random_frames(90);

        settle();
        if (mismatches == 0 && marks_due.size() == 0)
            $display("adaptive_mean_threshold_3x3_unit test passed");
        else
            $display("adaptive_mean_threshold_3x3_unit test failed");
        $finish;
    end

endmodule

### adaptive_mean_threshold_3x3_unit.f
+incdir+src
src/amt3x3_pkg.sv
src/amt3x3_in_if.sv
src/amt3x3_out_if.sv
src/amt3x3_line_mem.sv
src/amt3x3_out_fifo.sv
src/adaptive_mean_threshold_3x3_unit.sv
test/tb_top.sv
